/* rtl/sector_write_bitmap_assert.svh */
// Assertion macros for the sector write bitmap block.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef SECTOR_WRITE_BITMAP_ASSERT_SVH
`define SECTOR_WRITE_BITMAP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define SBW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sector_write_bitmap assertion failed");
// Next-cycle implication, disabled during reset.
`define SBW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sector_write_bitmap assertion failed");
`else
`define SBW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SBW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/sbw_pkg.sv */
// Shared types and constants of the sector write bitmap block.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none
package sbw_pkg;

    // Default map geometry.
    localparam int unsigned SBW_MAP_SECTORS = 1048576;
    localparam int unsigned SBW_WORD_BITS   = 32;

    // Register field widths and reset values.
    localparam int unsigned SHIFT_W  = 4;
    localparam int unsigned MAPPED_W = 21;
    localparam logic [SHIFT_W-1:0]  SHIFT_RESET  = 4'd9;
    localparam logic [MAPPED_W-1:0] MAPPED_RESET = 21'd1048576;
    localparam logic [SHIFT_W-1:0]  SHIFT_MIN    = 4'd9;
    localparam logic [SHIFT_W-1:0]  SHIFT_MAX    = 4'd12;

    // Register indexes as decoded from paddr[2].
    localparam logic REG_SECTOR_SHIFT   = 1'b0;
    localparam logic REG_MAPPED_SECTORS = 1'b1;

    // Request kinds.
    localparam logic KIND_MARK     = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_MARKED  = 3'd0;
    localparam logic [2:0] ST_CLEAR   = 3'd1;
    localparam logic [2:0] ST_SET     = 3'd2;
    localparam logic [2:0] ST_MIXED   = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;

    // Seen flags collected by a classify walk.
    localparam logic [1:0] SEEN_BOTH = 2'b11;

    // Current configuration.
    typedef struct packed {
        logic [SHIFT_W-1:0]  sector_shift;
        logic [MAPPED_W-1:0] mapped_sectors;
    } cfg_t;

    // Flags from the word unit for the masked part of one map word.
    typedef struct packed {
        logic any_set;
        logic any_clear;
    } word_flags_t;

endpackage
`default_nettype wire

/* rtl/sbw_apb_regs.sv */
// APB configuration registers: sector_shift and mapped_sectors.
// Depends on sbw_pkg for widths, reset values and register indexes.
`default_nettype none
module sbw_apb_regs
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    output sbw_pkg::cfg_t            cfg
);

    logic [sbw_pkg::SHIFT_W-1:0]  shift_reg;
    logic [sbw_pkg::MAPPED_W-1:0] mapped_reg;
    logic                         wr_en;

    // A write completes in the access cycle; the port never waits.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= sbw_pkg::SHIFT_RESET;
            mapped_reg <= sbw_pkg::MAPPED_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == sbw_pkg::REG_SECTOR_SHIFT)
            begin
                shift_reg <= pwdata[sbw_pkg::SHIFT_W-1:0];
            end
            else
            begin
                mapped_reg <= pwdata[sbw_pkg::MAPPED_W-1:0];
            end
        end
    end

    // Read data is the stored value, zero-extended.
    always_comb
    begin
        if (paddr[2] == sbw_pkg::REG_SECTOR_SHIFT)
        begin
            prdata = 32'(shift_reg);
        end
        else
        begin
            prdata = 32'(mapped_reg);
        end
    end

    assign cfg.sector_shift   = shift_reg;
    assign cfg.mapped_sectors = mapped_reg;

endmodule
`default_nettype wire

/* rtl/sbw_map_ram.sv */
// Single-port bitmap memory with registered read data.
// No package dependencies; sized by the top level.
`default_nettype none
module sbw_map_ram
#(
    parameter int unsigned WORD_BITS = 32,
    parameter int unsigned DEPTH     = 32768,
    localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        addr,
    input  wire logic [WORD_BITS-1:0] wdata,
    output logic      [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    // Write and registered read at the same address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* rtl/sbw_word_unit.sv */
// Shared word unit: builds the bit mask of a range inside one map word,
// merges it for a mark and tests it for a classify. Depends on sbw_pkg.
`default_nettype none
module sbw_word_unit
#(
    parameter int unsigned WORD_BITS = 32,
    localparam int unsigned BW       = $clog2(WORD_BITS)
)
(
    input  wire logic [WORD_BITS-1:0] word,
    input  wire logic [BW-1:0]        lo,
    input  wire logic [BW-1:0]        hi,
    output logic      [WORD_BITS-1:0] merged,
    output sbw_pkg::word_flags_t      flags
);

    logic [WORD_BITS-1:0] mask;

    // Bits lo through hi inclusive; ~hi equals WORD_BITS-1-hi for a power of two.
    assign mask = ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (~hi));

    assign merged          = word | mask;
    assign flags.any_set   = |(word & mask);
    assign flags.any_clear = |(~word & mask);

endmodule
`default_nettype wire

/* rtl/sector_write_bitmap.sv */
// Top level of the sector write bitmap: sequencer, registers, memory, word unit.
// Depends on sbw_pkg, sbw_apb_regs, sbw_map_ram, sbw_word_unit and the assert header.
//
// Usage: one dirty bit per sector, held in a word-wide memory. An item is
// accepted when start is high and busy is low; kind 0 marks a byte range as
// written, kind 1 classifies it. Exactly one result follows per item: status
// is valid while done is high for one cycle and must be taken then; the
// receiver cannot stall the block.
// Sequence: a rejected item or an empty mark is answered from the check state,
// without a memory access. Otherwise the walk reads each map word touched, then
// tests it or merges and writes it, before reading the next word; a classify
// stops at the first word where both clear and set bits have been seen.
// The single memory port and the one word unit keep the walk to one word at a time.
// busy stays high from acceptance until done.
// Reset: the registers return to sector_shift 9 and mapped_sectors 1048576,
// and a clearing pass writes zero to every map word, one word a cycle
// (MAP_SECTORS/WORD_BITS words, 32768 by default) with busy high. APB writes
// are taken during that pass. WORD_BITS must be a power of two.
`default_nettype none
`include "sector_write_bitmap_assert.svh"
module sector_write_bitmap
#(
    parameter int unsigned MAP_SECTORS = sbw_pkg::SBW_MAP_SECTORS,
    parameter int unsigned WORD_BITS   = sbw_pkg::SBW_WORD_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        kind,
    input  wire logic [31:0] byte_offset,
    input  wire logic [23:0] byte_length,
    output logic             done,
    output logic      [2:0]  status
);

    localparam int unsigned NWORDS = (MAP_SECTORS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int unsigned BW     = $clog2(WORD_BITS);
    localparam int unsigned SIDX_W = $clog2(MAP_SECTORS);
    localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

    // Sequencer state codes.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_PROC  = 3'd4;

    sbw_pkg::cfg_t        cfg;
    sbw_pkg::word_flags_t flags;

    logic [2:0]           state_reg, state_next;
    logic                 kind_reg;
    logic [31:0]          off_reg;
    logic [23:0]          len_reg;
    logic [AW-1:0]        wcur_reg, wcur_next;
    logic [AW-1:0]        wlast_reg, wlast_next;
    logic [BW-1:0]        lo_first_reg, lo_first_next;
    logic [BW-1:0]        hi_last_reg, hi_last_next;
    logic                 first_word_reg, first_word_next;
    logic [1:0]           seen_reg, seen_next;
    logic                 done_reg, done_next;
    logic [2:0]           status_reg, status_next;

    logic                 accept;
    logic [3:0]           sh_eff;
    logic [31:0]          smask;
    logic [31:0]          first_full;
    logic [23:0]          count_full;
    logic [32:0]          sum_full;
    logic [32:0]          last_full;
    logic [32:0]          limit;
    logic                 invalid;
    logic [SIDX_W-1:0]    first_idx;
    logic [SIDX_W-1:0]    last_idx;
    logic [BW-1:0]        lo_cur;
    logic [BW-1:0]        hi_cur;
    logic [1:0]           seen_new;
    logic                 ram_we;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] merged;

    sbw_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sbw_map_ram
    #(
        .WORD_BITS (WORD_BITS),
        .DEPTH     (NWORDS)
    )
    u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .addr  (wcur_reg),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    sbw_word_unit
    #(
        .WORD_BITS (WORD_BITS)
    )
    u_word
    (
        .word   (ram_rdata),
        .lo     (lo_cur),
        .hi     (hi_cur),
        .merged (merged),
        .flags  (flags)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign status = status_reg;

    // Effective sector shift, clamped to the supported sector sizes.
    always_comb
    begin
        if (cfg.sector_shift < sbw_pkg::SHIFT_MIN)
        begin
            sh_eff = sbw_pkg::SHIFT_MIN;
        end
        else if (cfg.sector_shift > sbw_pkg::SHIFT_MAX)
        begin
            sh_eff = sbw_pkg::SHIFT_MAX;
        end
        else
        begin
            sh_eff = cfg.sector_shift;
        end
    end

    // Range check: alignment, empty classify and the end against the limit.
    always_comb
    begin
        smask      = ~(32'hFFFF_FFFF << sh_eff);
        first_full = off_reg >> sh_eff;
        count_full = len_reg >> sh_eff;
        sum_full   = {1'b0, first_full} + 33'(count_full);
        last_full  = sum_full - 33'd1;
        if (33'(cfg.mapped_sectors) < 33'(MAP_SECTORS))
        begin
            limit = 33'(cfg.mapped_sectors);
        end
        else
        begin
            limit = 33'(MAP_SECTORS);
        end
        invalid = (|(off_reg & smask)) || (|(len_reg & smask[23:0])) ||
                  ((kind_reg == sbw_pkg::KIND_CLASSIFY) && (len_reg == 24'd0)) ||
                  (sum_full > limit);
        first_idx = first_full[SIDX_W-1:0];
        last_idx  = last_full[SIDX_W-1:0];
    end

    // Bit bounds of the current word and the updated seen flags.
    always_comb
    begin
        lo_cur   = first_word_reg ? lo_first_reg : {BW{1'b0}};
        hi_cur   = (wcur_reg == wlast_reg) ? hi_last_reg : {BW{1'b1}};
        seen_new = seen_reg | {flags.any_set, flags.any_clear};
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        wcur_next       = wcur_reg;
        wlast_next      = wlast_reg;
        lo_first_next   = lo_first_reg;
        hi_last_next    = hi_last_reg;
        first_word_next = first_word_reg;
        seen_next       = seen_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        ram_we          = 1'b0;
        ram_wdata       = merged;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = {WORD_BITS{1'b0}};
                if (wcur_reg == LAST_WORD)
                begin
                    wcur_next  = {AW{1'b0}};
                    state_next = S_IDLE;
                end
                else
                begin
                    wcur_next = wcur_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (invalid)
                begin
                    done_next   = 1'b1;
                    status_next = sbw_pkg::ST_INVALID;
                    state_next  = S_IDLE;
                end
                else if (len_reg == 24'd0)
                begin
                    done_next   = 1'b1;
                    status_next = sbw_pkg::ST_MARKED;
                    state_next  = S_IDLE;
                end
                else
                begin
                    wcur_next       = AW'(first_idx >> BW);
                    wlast_next      = AW'(last_idx >> BW);
                    lo_first_next   = first_idx[BW-1:0];
                    hi_last_next    = last_idx[BW-1:0];
                    first_word_next = 1'b1;
                    seen_next       = 2'b00;
                    state_next      = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_PROC;
            end
            S_PROC:
            begin
                ram_we    = (kind_reg == sbw_pkg::KIND_MARK);
                seen_next = seen_new;
                if ((wcur_reg == wlast_reg) ||
                    ((kind_reg == sbw_pkg::KIND_CLASSIFY) && (seen_new == sbw_pkg::SEEN_BOTH)))
                begin
                    done_next = 1'b1;
                    if (kind_reg == sbw_pkg::KIND_CLASSIFY)
                    begin
                        status_next = {1'b0, seen_new};
                    end
                    else
                    begin
                        status_next = sbw_pkg::ST_MARKED;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    wcur_next       = wcur_reg + AW'(1);
                    first_word_next = 1'b0;
                    state_next      = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            wcur_reg  <= {AW{1'b0}};
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wcur_reg  <= wcur_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            off_reg  <= byte_offset;
            len_reg  <= byte_length;
        end
        wlast_reg      <= wlast_next;
        lo_first_reg   <= lo_first_next;
        hi_last_reg    <= hi_last_next;
        first_word_reg <= first_word_next;
        seen_reg       <= seen_next;
        status_reg     <= status_next;
    end

    // Checks on the sequencer.
    `SBW_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy && (state_reg == S_CHECK))
    `SBW_ASSERT_NXT(a_done_single, clk, rst_n, done, !done)
    `SBW_ASSERT_IMP(a_no_done_clear, clk, rst_n, state_reg == S_CLEAR, !done)
    `SBW_ASSERT_IMP(a_mark_status, clk, rst_n, done && (kind_reg == sbw_pkg::KIND_MARK), (status == sbw_pkg::ST_MARKED) || (status == sbw_pkg::ST_INVALID))

endmodule
`default_nettype wire
